### hdl/skpl_pkg.sv
// Shared types and constants for the soft-knee peak limiter.
// Depends on nothing; every other file of the block imports it.

package skpl_pkg;

  localparam int SAMPLE_W   = 24;
  localparam int LEVEL_W    = 23;
  localparam int GAIN_W     = 17;
  localparam int COEF_W     = 16;
  localparam int CCOUNT_W   = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 23;
  localparam int DIV_CNT_W  = 5;
  localparam int PROD_W     = 43;

  localparam logic [GAIN_W-1:0]   UNITY_GAIN     = 17'd65536;
  localparam logic [DIV_CNT_W-1:0] DIV_LAST      = 5'd16;

  localparam logic [LEVEL_W-1:0]  KNEE_RESET     = 23'd371195;
  localparam logic [LEVEL_W-1:0]  CEILING_RESET  = 23'd467137;
  localparam logic [COEF_W-1:0]   COEF_RESET     = 16'd65490;
  localparam logic [CCOUNT_W-1:0] CCOUNT_RESET   = 2'd2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KNEE_START    = 3'd0,
    REG_CEILING       = 3'd1,
    REG_RELEASE_COEF  = 3'd2,
    REG_CHANNEL_COUNT = 3'd3
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_DIV,
    ST_REL,
    ST_GAIN,
    ST_MULO,
    ST_RND,
    ST_FIN
  } state_t;

endpackage

### hdl/skpl_if.sv
// Channel interfaces of the soft-knee peak limiter: samples, results and
// configuration writes. Depends on skpl_pkg for the field widths.

interface skpl_sample_if
  import skpl_pkg::*;
  ();
  logic                       valid;
  logic                       ready;
  logic                       channel;
  logic signed [SAMPLE_W-1:0] sample_in;
  logic                       sample_invalid;

  modport source (output valid, output channel, output sample_in, output sample_invalid,
                  input ready);
  modport sink (input valid, input channel, input sample_in, input sample_invalid,
                output ready);
endinterface

interface skpl_result_if
  import skpl_pkg::*;
  ();
  logic                       valid;
  logic                       ready;
  logic                       channel_out;
  logic signed [SAMPLE_W-1:0] sample_out;

  modport source (output valid, output channel_out, output sample_out, input ready);
  modport sink (input valid, input channel_out, input sample_out, output ready);
endinterface

interface skpl_cfg_if
  import skpl_pkg::*;
  ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  reg_index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output reg_index, output data, input ready);
  modport sink (input valid, input reg_index, input data, output ready);
endinterface

### hdl/soft_knee_peak_limiter.sv
// Top level of the soft-knee peak limiter: sequencer, shared divider step,
// shared multiplier and per-channel gain store. Depends on skpl_pkg, skpl_if.
//
//  Channel      Role    Payload                                  Transfer when
//  sample_chan  sink    channel, sample_in, sample_invalid       valid & ready
//  result_chan  source  channel_out, sample_out                  valid & ready
//  cfg_chan     sink    reg_index, data                          valid & ready
//
// An item occupies the sequencer from its transfer until its result is loaded
// into the output register. A pass-through sample goes from set-up straight to the
// final state. A limited sample steps through release, gain update (skipped when it
// attacks), output multiply and rounding; a sample at or above the ceiling first
// runs the restoring divider, which forms ceiling / magnitude one quotient bit per
// cycle.
// Reset is synchronous and restores the register defaults and unity gain on
// every channel. The output register decouples the two sides: a new sample
// is taken while the previous result still waits, and the sequencer holds in
// its final state only if that earlier result has not yet been taken.

module soft_knee_peak_limiter
  import skpl_pkg::*;
#(
  parameter int MAX_CHANNELS = 2
) (
  input  logic           clk,
  input  logic           rst,
  skpl_sample_if.sink    sample_chan,
  skpl_result_if.source  result_chan,
  skpl_cfg_if.sink       cfg_chan
);

  localparam int IDX_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam logic [3:0] MAX_CH = 4'(MAX_CHANNELS);

  // Configuration registers. Writes are accepted in every cycle.
  logic [LEVEL_W-1:0]  knee_start;
  logic [LEVEL_W-1:0]  ceiling;
  logic [COEF_W-1:0]   release_coef;
  logic [CCOUNT_W-1:0] channel_count;

  assign cfg_chan.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      knee_start    <= KNEE_RESET;
      ceiling       <= CEILING_RESET;
      release_coef  <= COEF_RESET;
      channel_count <= CCOUNT_RESET;
    end else if (cfg_chan.valid) begin
      unique case (cfg_chan.reg_index)
        REG_KNEE_START:    knee_start    <= cfg_chan.data;
        REG_CEILING:       ceiling       <= cfg_chan.data;
        REG_RELEASE_COEF:  release_coef  <= cfg_chan.data[COEF_W-1:0];
        REG_CHANNEL_COUNT: channel_count <= cfg_chan.data[CCOUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer state and item registers.
  state_t state, state_next;

  logic                       ch;
  logic signed [SAMPLE_W-1:0] raw;
  logic                       inv;
  logic [SAMPLE_W-1:0]        ax;
  logic [SAMPLE_W-1:0]        rem;
  logic [GAIN_W-1:0]          tgt;
  logic [DIV_CNT_W-1:0]       div_cnt;
  logic [GAIN_W-1:0]          gain_val;
  logic signed [PROD_W-1:0]   prod;
  logic signed [SAMPLE_W-1:0] res;
  logic [GAIN_W-1:0]          channel_gain [MAX_CHANNELS];

  logic                       out_valid;
  logic                       out_channel;
  logic signed [SAMPLE_W-1:0] out_sample;

  logic sample_fire;
  logic out_load;

  assign sample_chan.ready = (state == ST_IDLE);
  assign sample_fire       = sample_chan.valid && sample_chan.ready;
  assign out_load          = (state == ST_FIN) && (!out_valid || result_chan.ready);

  // Limiting applies to channels below min(channel_count, MAX_CHANNELS).
  logic [3:0]       ch_limit;
  logic             pass;
  logic [IDX_W-1:0] gidx;

  assign ch_limit = ({2'b00, channel_count} < MAX_CH) ? {2'b00, channel_count} : MAX_CH;
  assign pass     = ({3'b000, ch} >= ch_limit);
  assign gidx     = IDX_W'(ch);

  // An invalid sample counts as silence; its magnitude is taken as unsigned so
  // that the most negative code gives 8388608.
  logic signed [SAMPLE_W-1:0] x;
  logic [SAMPLE_W-1:0]        x_abs;

  assign x     = inv ? '0 : raw;
  assign x_abs = x[SAMPLE_W-1] ? (~x + 1'b1) : x;

  // One restoring divider step. The remainder stays below the divisor, so a
  // shifted remainder fits in one extra bit.
  logic [SAMPLE_W:0]   div_trial;
  logic                div_ge;
  logic [SAMPLE_W:0]   div_diff;

  assign div_trial = (div_cnt == '0) ? {1'b0, rem} : {rem, 1'b0};
  assign div_ge    = (div_trial >= {1'b0, ax});
  assign div_diff  = div_trial - {1'b0, ax};

  // Release step and gain held for the current channel.
  logic [GAIN_W-1:0] gain_cur;
  logic              attack;
  logic [GAIN_W-1:0] rel_diff;
  logic [GAIN_W-1:0] gain_rel;

  assign gain_cur = channel_gain[gidx];
  assign attack   = (tgt < gain_cur);
  assign rel_diff = tgt - gain_cur;
  assign gain_rel = tgt - prod[32:16];

  // The shared multiplier serves the release step and the output scaling.
  logic signed [SAMPLE_W:0] mul_a;
  logic signed [GAIN_W:0]   mul_b;
  logic signed [PROD_W-1:0] mul_p;

  always_comb begin
    if (state == ST_REL) begin
      mul_a = $signed({8'b0, rel_diff});
      mul_b = $signed({2'b0, release_coef});
    end else begin
      mul_a = $signed({x[SAMPLE_W-1], x});
      mul_b = $signed({1'b0, gain_val});
    end
    mul_p = mul_a * mul_b;
  end

  // Round half up, then saturate to the sample range.
  logic signed [PROD_W-1:0] rnd;
  logic signed [26:0]       rnd_sh;
  logic signed [SAMPLE_W-1:0] rnd_sat;

  always_comb begin
    rnd    = prod + 43'sd32768;
    rnd_sh = rnd[42:16];
    if (rnd_sh > 27'sd8388607) begin
      rnd_sat = 24'sh7FFFFF;
    end else if (rnd_sh < -27'sd8388608) begin
      rnd_sat = 24'sh800000;
    end else begin
      rnd_sat = rnd_sh[SAMPLE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (sample_fire) begin
          state_next = ST_SETUP;
        end
      end
      ST_SETUP: begin
        if (pass) begin
          state_next = ST_FIN;
        end else if (x_abs <= {1'b0, knee_start} || x_abs < {1'b0, ceiling}) begin
          state_next = ST_REL;
        end else begin
          state_next = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_cnt == DIV_LAST) begin
          state_next = ST_REL;
        end
      end
      ST_REL: begin
        state_next = attack ? ST_MULO : ST_GAIN;
      end
      ST_GAIN: state_next = ST_MULO;
      ST_MULO: state_next = ST_RND;
      ST_RND:  state_next = ST_FIN;
      ST_FIN: begin
        if (out_load) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (sample_fire) begin
      ch  <= sample_chan.channel;
      raw <= sample_chan.sample_in;
      inv <= sample_chan.sample_invalid;
    end
    unique case (state)
      ST_SETUP: begin
        ax      <= x_abs;
        rem     <= {1'b0, ceiling};
        div_cnt <= '0;
        tgt     <= UNITY_GAIN;
        res     <= raw;
      end
      ST_DIV: begin
        rem     <= div_ge ? div_diff[SAMPLE_W-1:0] : div_trial[SAMPLE_W-1:0];
        tgt     <= {tgt[GAIN_W-2:0], div_ge};
        div_cnt <= div_cnt + 1'b1;
      end
      ST_REL: begin
        prod     <= mul_p;
        gain_val <= tgt;
      end
      ST_GAIN: gain_val <= gain_rel;
      ST_MULO: prod <= mul_p;
      ST_RND:  res  <= rnd_sat;
      default: ;
    endcase
  end

  // Gain store: unity after reset, updated once per limited sample.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_CHANNELS; i++) begin
        channel_gain[i] <= UNITY_GAIN;
      end
    end else if (state == ST_REL && attack) begin
      channel_gain[gidx] <= tgt;
    end else if (state == ST_GAIN) begin
      channel_gain[gidx] <= gain_rel;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (result_chan.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_channel <= ch;
      out_sample  <= res;
    end
  end

  assign result_chan.valid       = out_valid;
  assign result_chan.channel_out = out_channel;
  assign result_chan.sample_out  = out_sample;

  // A transfer on the sample channel always starts the set-up step.
  a_fire_setup: assert property (@(posedge clk) disable iff (rst)
    sample_fire |=> (state == ST_SETUP))
    else $error("sample transfer did not start the sequencer");

  // Once the first quotient bit is out, the divider remainder stays below the
  // divisor. Before that it equals the ceiling, which may match the magnitude.
  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV && div_cnt != '0) |-> (rem < ax))
    else $error("divider remainder reached the divisor");

  // The quotient of ceiling over a magnitude no smaller than it never exceeds unity.
  a_quot_unity: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV && div_cnt == DIV_LAST) |=> (tgt <= UNITY_GAIN))
    else $error("target gain above unity after division");

  // The gain used for scaling never exceeds unity.
  a_gain_unity: assert property (@(posedge clk) disable iff (rst)
    (state == ST_MULO) |-> (gain_val <= UNITY_GAIN))
    else $error("scaling gain above unity");

endmodule

### test/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the soft-knee peak limiter: directed corners, randomised phases
// under several register settings and idling modes, and one long output hold.
// Depends on skpl_pkg and the channel interfaces in skpl_if.

module tb;
  import skpl_pkg::*;

  // The block is built with two channels; the predictor mirrors that.
  localparam int NUM_CHANNELS = 2;

  // Full-scale magnitude of a Q1.23 sample; only the most negative code reaches it.
  localparam int FULL_SCALE_MAG = 8388608;
  localparam int LEVEL_MAX      = 8388607;
  localparam longint SAT_HIGH   = 64'sd8388607;
  localparam longint SAT_LOW    = -64'sd8388608;

  // A register index past the end of the list: the block must ignore writes to it.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd6;

  // Items per randomised phase and the number of phases (880 samples in all).
  localparam int PHASE_ITEMS = 110;
  localparam int NUM_PHASES  = 8;

  // The slowest item (a sample at or above the ceiling) runs the whole divider, and the
  // quiet stretch after the last result is sized to leave the block certainly idle.
  localparam int SETTLE_CYCLES = 32;

  // The receiver's deliberate hold-off, long enough to fill the block and stall its input.
  localparam int LONG_HOLD = 400;

  // Cycles without any transfer before the run is declared hung. The longest legitimate
  // silence is the long hold plus random stalls and gaps.
  localparam int WATCHDOG_LIMIT = 3000;

  // Magnitude bands used to shape random samples around the current knee and ceiling.
  typedef enum int {
    LVL_QUIET,
    LVL_KNEE,
    LVL_OVER,
    LVL_FULL,
    LVL_ANY
  } level_t;

  typedef struct packed {
    logic                       channel;
    logic signed [SAMPLE_W-1:0] level;
  } limiter_out_t;

  logic clk = 1'b0;
  logic rst;

  skpl_sample_if sample_bus ();
  skpl_result_if result_bus ();
  skpl_cfg_if    cfg_bus ();

  soft_knee_peak_limiter #(
    .MAX_CHANNELS(NUM_CHANNELS)
  ) u_top (
    .clk         (clk),
    .rst         (rst),
    .sample_chan (sample_bus),
    .result_chan (result_bus),
    .cfg_chan    (cfg_bus)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predictor state: its own copy of the registers and of the smoothed gain per channel.
  logic [LEVEL_W-1:0]  cfg_knee;
  logic [LEVEL_W-1:0]  cfg_ceiling;
  logic [COEF_W-1:0]   cfg_coef;
  logic [CCOUNT_W-1:0] cfg_count;
  logic [GAIN_W-1:0]   gain_state [NUM_CHANNELS];

  // Outputs predicted at each accepted sample, oldest first.
  limiter_out_t pending_outputs[$];

  int fail_count     = 0;
  int samples_sent   = 0;
  int results_seen   = 0;
  int reg_writes     = 0;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int quiet_cycles   = 0;

  // Raised once by the main sequence; the receiver process then counts its own hold-off.
  logic long_hold_req = 1'b0;

  // ---------------------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------------------

  // Target gain for a magnitude: unity up to the knee, ceiling / magnitude from the ceiling
  // up, and the quadratic blend in between, always saturated to unity.
  function automatic logic [GAIN_W-1:0] gain_target(input logic [SAMPLE_W-1:0] mag);
    longint unsigned m, ceil_q, upper, span, frac, frac_sq, excess, tgt;
    m      = mag;
    ceil_q = cfg_ceiling;
    ceil_q = ceil_q << 16;
    if (m <= cfg_knee) begin
      tgt = UNITY_GAIN;
    end else begin
      upper = ceil_q / m;
      if (m >= cfg_ceiling) begin
        tgt = upper;
      end else begin
        span    = cfg_ceiling - cfg_knee;
        frac    = ((m - cfg_knee) << 16) / span;
        frac_sq = (frac * frac) >> 16;
        excess  = (upper > UNITY_GAIN) ? upper - UNITY_GAIN : 64'd0;
        tgt     = UNITY_GAIN + ((frac_sq * excess) >> 16);
      end
    end
    if (tgt > UNITY_GAIN) tgt = UNITY_GAIN;
    return tgt[GAIN_W-1:0];
  endfunction

  // Limits one sample, updating the channel's gain exactly as the block should.
  function automatic limiter_out_t limit_sample(input logic ch,
                                                input logic signed [SAMPLE_W-1:0] smp,
                                                input logic inv);
    limiter_out_t             res;
    int unsigned              limited;
    longint                   x, prod, scaled;
    logic [SAMPLE_W-1:0]      mag;
    logic [GAIN_W-1:0]        tgt, g;
    logic [GAIN_W+COEF_W-1:0] pull;
    res.channel = ch;
    limited = (cfg_count < NUM_CHANNELS) ? int'(cfg_count) : NUM_CHANNELS;
    // Unlimited channels pass the raw code through, invalid or not, and keep their gain.
    if (int'(ch) >= limited) begin
      res.level = smp;
      return res;
    end
    // An invalid sample counts as silence, so the gain releases towards unity.
    x   = inv ? 64'sd0 : longint'(smp);
    mag = (x < 0) ? SAMPLE_W'(-x) : SAMPLE_W'(x);
    tgt = gain_target(mag);
    g   = gain_state[ch];
    if (tgt < g) begin
      g = tgt;
    end else begin
      pull = (tgt - g) * cfg_coef;
      g    = tgt - pull[GAIN_W+COEF_W-1:COEF_W];
    end
    gain_state[ch] = g;
    prod   = x * longint'(g) + 64'sd32768;
    scaled = prod >>> 16;
    if (scaled > SAT_HIGH) scaled = SAT_HIGH;
    else if (scaled < SAT_LOW) scaled = SAT_LOW;
    res.level = scaled[SAMPLE_W-1:0];
    return res;
  endfunction

  // Random sample whose magnitude falls into the requested band of the current settings.
  function automatic int pick_level(input level_t kind);
    int unsigned mag;
    case (kind)
      LVL_QUIET: mag = $urandom_range(int'(cfg_knee), 0);
      LVL_KNEE:  mag = $urandom_range(int'(cfg_ceiling), int'(cfg_knee));
      LVL_OVER:  mag = $urandom_range(FULL_SCALE_MAG, int'(cfg_ceiling));
      LVL_FULL:  mag = ($urandom_range(1, 0) != 0) ? FULL_SCALE_MAG : LEVEL_MAX;
      default:   return int'($urandom);
    endcase
    if (mag >= FULL_SCALE_MAG) return -FULL_SCALE_MAG;
    return ($urandom_range(1, 0) != 0) ? -int'(mag) : int'(mag);
  endfunction

  // ---------------------------------------------------------------------------------------
  // Sender side
  // ---------------------------------------------------------------------------------------

  // Offers one sample, with a random gap first when the sender idles. Valid is left high
  // after the transfer so that back-to-back samples need no second assignment in a step.
  task automatic send_sample(input logic ch, input int value, input logic inv);
    logic signed [SAMPLE_W-1:0] smp;
    smp = value[SAMPLE_W-1:0];
    if (send_idle_pct != 0 && $urandom_range(99, 0) < send_idle_pct) begin
      sample_bus.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99, 0) < send_idle_pct);
    end
    sample_bus.valid          <= 1'b1;
    sample_bus.channel        <= ch;
    sample_bus.sample_in      <= smp;
    sample_bus.sample_invalid <= inv;
    @(posedge clk);
    while (!sample_bus.ready) @(posedge clk);
    pending_outputs.push_back(limit_sample(ch, smp, inv));
    samples_sent++;
  endtask

  task automatic send_random(input level_t kind);
    send_sample(1'($urandom_range(1, 0)), pick_level(kind), $urandom_range(15, 0) == 0);
  endtask

  // Stops offering samples and waits until every predicted output has been taken and the
  // sequencer has had time to come to rest.
  task automatic settle();
    sample_bus.valid <= 1'b0;
    while (pending_outputs.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // One register write; the predictor follows with the same bit masking as the block.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_bus.valid     <= 1'b1;
    cfg_bus.reg_index <= idx;
    cfg_bus.data      <= data;
    @(posedge clk);
    while (!cfg_bus.ready) @(posedge clk);
    case (idx)
      REG_KNEE_START:    cfg_knee    = data[LEVEL_W-1:0];
      REG_CEILING:       cfg_ceiling = data[LEVEL_W-1:0];
      REG_RELEASE_COEF:  cfg_coef    = data[COEF_W-1:0];
      REG_CHANNEL_COUNT: cfg_count   = data[CCOUNT_W-1:0];
      default: ;
    endcase
    reg_writes++;
    cfg_bus.valid <= 1'b0;
    @(posedge clk);
  endtask

  // Writes all four registers once the block is idle. The gain state is untouched.
  task automatic configure(input int knee, input int ceil_level, input int coef, input int count);
    settle();
    write_reg(REG_KNEE_START,    knee[CFG_DATA_W-1:0]);
    write_reg(REG_CEILING,       ceil_level[CFG_DATA_W-1:0]);
    write_reg(REG_RELEASE_COEF,  coef[CFG_DATA_W-1:0]);
    write_reg(REG_CHANNEL_COUNT, count[CFG_DATA_W-1:0]);
  endtask

  // ---------------------------------------------------------------------------------------
  // Receiver side: random stalls, the long hold-off, and the check of every transfer.
  // ---------------------------------------------------------------------------------------

  task automatic check_output(input logic ch, input logic signed [SAMPLE_W-1:0] smp);
    limiter_out_t want;
    results_seen++;
    if (pending_outputs.size() == 0) begin
      fail_count++;
      if (fail_count <= 10)
        $display("%0t: output with nothing expected: channel %0d sample %0d", $realtime, ch, smp);
      return;
    end
    want = pending_outputs.pop_front();
    if (want.channel !== ch || want.level !== smp) begin
      fail_count++;
      if (fail_count <= 10)
        $display("%0t: mismatch: expected channel %0d sample %0d, got channel %0d sample %0d",
                 $realtime, want.channel, want.level, ch, smp);
    end
  endtask

  initial begin : receiver
    int  hold_left;
    bit  hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    result_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (result_bus.valid === 1'b1 && result_bus.ready === 1'b1)
        check_output(result_bus.channel_out, result_bus.sample_out);
      if (long_hold_req && !hold_done) begin
        hold_left = LONG_HOLD;
        hold_done = 1'b1;
      end
      if (hold_left != 0) begin
        hold_left--;
        result_bus.ready <= 1'b0;
      end else begin
        result_bus.ready <= ($urandom_range(99, 0) >= recv_stall_pct);
      end
    end
  end

  // Watchdog: counts cycles in which no channel completes a transfer.
  always @(posedge clk) begin
    if (rst || (sample_bus.valid && sample_bus.ready) || (result_bus.valid && result_bus.ready)
        || (cfg_bus.valid && cfg_bus.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no transfer for %0d cycles, %0d outputs outstanding", $realtime,
               WATCHDOG_LIMIT, pending_outputs.size());
      $display("Some tests failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------------------

  // Reset values: silence, both full-scale extremes, the knee and ceiling edges, a level
  // inside the knee (whose target gain is unity), and an invalid sample that releases the gain.
  task automatic test_default_registers();
    send_sample(1'b0, 0, 1'b0);
    send_sample(1'b1, LEVEL_MAX, 1'b0);
    send_sample(1'b0, -FULL_SCALE_MAG, 1'b0);
    send_sample(1'b1, int'(KNEE_RESET), 1'b0);
    send_sample(1'b0, 400000, 1'b0);
    send_sample(1'b1, -int'(CEILING_RESET), 1'b0);
    send_sample(1'b0, LEVEL_MAX, 1'b1);
    send_sample(1'b0, 1000, 1'b0);
  endtask

  // Register corners: fewer limited channels than exist (one and none), a count above
  // the channel total, a write to an unused index, a zero ceiling, a knee above the
  // ceiling, instant and slowest release, and both levels at their maximum.
  task automatic test_register_corners();
    configure(int'(KNEE_RESET), int'(CEILING_RESET), int'(COEF_RESET), 1);
    // Channel 1 is not limited: its raw code passes through although it is flagged invalid.
    send_sample(1'b1, -FULL_SCALE_MAG, 1'b1);
    send_sample(1'b0, 500000, 1'b0);
    configure(int'(KNEE_RESET), int'(CEILING_RESET), int'(COEF_RESET), 0);
    send_sample(1'b0, LEVEL_MAX, 1'b0);
    configure(int'(KNEE_RESET), int'(CEILING_RESET), int'(COEF_RESET), 3);
    write_reg(REG_SPARE, {CFG_DATA_W{1'b1}});
    send_sample(1'b1, LEVEL_MAX, 1'b0);
    // Zero ceiling: any magnitude above the knee drives the gain to zero.
    configure(0, 0, int'(COEF_RESET), 2);
    send_sample(1'b0, 1, 1'b0);
    send_sample(1'b0, 12345, 1'b1);
    // Knee above the ceiling, with instant release.
    configure(500000, 300000, 0, 2);
    send_sample(1'b1, 400000, 1'b0);
    send_sample(1'b1, 200000, 1'b0);
    configure(int'(KNEE_RESET), int'(CEILING_RESET), 65535, 2);
    send_sample(1'b0, LEVEL_MAX, 1'b0);
    send_sample(1'b0, 1, 1'b0);
    // Both levels at full scale: only the most negative code crosses the knee.
    configure(LEVEL_MAX, LEVEL_MAX, int'(COEF_RESET), 2);
    send_sample(1'b0, -FULL_SCALE_MAG, 1'b0);
    send_sample(1'b1, LEVEL_MAX, 1'b0);
  endtask

  // Randomised phases. Samples come in bursts of one magnitude band so that loud passages
  // pull the gain down and quiet ones let it release; each phase uses its own settings and
  // one of four idling modes.
  task automatic test_random_phases();
    int     phase, done, burst, knee;
    level_t kind;
    for (phase = 0; phase < NUM_PHASES; phase++) begin
      knee = $urandom_range(700000, 1000);
      case (phase)
        0: configure(int'(KNEE_RESET), int'(CEILING_RESET), int'(COEF_RESET), 2);
        1: configure(0, LEVEL_MAX, 0, 3);
        2: configure(knee, knee + $urandom_range(500000, 1), $urandom_range(65535, 0), 1);
        3: configure(LEVEL_MAX, 1, 65535, 2);
        4: configure(knee, $urandom_range(knee, 1), $urandom_range(65535, 0), 2);
        // Junk above the register widths must be dropped by the block.
        5: configure(knee, knee + $urandom_range(500000, 1), int'($urandom), int'($urandom));
        6: configure(0, $urandom_range(2000000, 1), $urandom_range(65535, 60000), 3);
        default: configure(knee, knee + $urandom_range(500000, 1),
                           $urandom_range(65535, 60000), 2);
      endcase
      case (phase % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 82; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 82; end
        default: begin send_idle_pct = 22; recv_stall_pct = 22; end
      endcase
      done = 0;
      while (done < PHASE_ITEMS) begin
        burst = $urandom_range(20, 3);
        // The last burst of a phase is trimmed so each phase sends exactly its share.
        if (burst > PHASE_ITEMS - done) burst = PHASE_ITEMS - done;
        kind  = level_t'($urandom_range(int'(LVL_ANY), int'(LVL_QUIET)));
        repeat (burst) begin
          send_random(kind);
          done++;
        end
      end
    end
  endtask

  // The receiver stops for a long stretch while samples keep coming, so the output register
  // and the sequencer fill and the input must stall without losing or reordering anything.
  task automatic test_output_hold();
    settle();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    long_hold_req <= 1'b1;
    repeat (40) send_random(LVL_ANY);
    settle();
  endtask

  // ---------------------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------------------

  initial begin
    rst                       <= 1'b1;
    sample_bus.valid          <= 1'b0;
    sample_bus.channel        <= 1'b0;
    sample_bus.sample_in      <= '0;
    sample_bus.sample_invalid <= 1'b0;
    cfg_bus.valid             <= 1'b0;
    cfg_bus.reg_index         <= REG_KNEE_START;
    cfg_bus.data              <= '0;
    cfg_knee    = KNEE_RESET;
    cfg_ceiling = CEILING_RESET;
    cfg_coef    = COEF_RESET;
    cfg_count   = CCOUNT_RESET;
    for (int i = 0; i < NUM_CHANNELS; i++) gain_state[i] = UNITY_GAIN;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_default_registers();
    test_register_corners();
    test_random_phases();
    test_output_hold();
    settle();

    fail_count += pending_outputs.size();
    $display("Covered %0d samples and %0d checked outputs over %0d register writes,",
             samples_sent, results_seen, reg_writes);
    $display("with four idling modes and a %0d-cycle output hold.", LONG_HOLD);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
